### sv/scfp_pkg.sv
// shared types, constants and helpers for the sum-checked frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package scfp_pkg;

    localparam int SCFP_MAX_PAYLOAD = 32;

    localparam int LEN_W     = 6;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 2'd2;

    localparam logic [7:0] SOF_ONE_RESET = 8'h55;
    localparam logic [7:0] SOF_TWO_RESET = 8'hAA;
    localparam logic [7:0] VERSION_RESET = 8'h01;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0]       command;
        logic [7:0]       sequence_res;
        logic [LEN_W-1:0] frame_length;
    } frame_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic wr_slot;
        logic rd_slot;
    } queue_status_t;

    // bits needed to count payload bytes from zero up to max_payload
    function automatic int payload_idx_w(input int max_payload);
        return $clog2(max_payload + 1);
    endfunction

endpackage

`default_nettype wire

### sv/scfp_front.sv
// byte parser: hunts for start bytes, checks version, length and checksum,
// writes payload into the free buffer slot; uses scfp_pkg
`default_nettype none

module scfp_front #(
    parameter int MAX_PAYLOAD = scfp_pkg::SCFP_MAX_PAYLOAD
) (
    input  wire                                           aclk,
    input  wire                                           aresetn,
    input  wire                                           cfg_valid,
    output logic                                          cfg_ready,
    input  wire  [scfp_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  wire  [7:0]                                    cfg_data,
    input  wire                                           s_valid,
    output logic                                          s_ready,
    input  wire  [7:0]                                    s_rx_byte,
    input  scfp_pkg::queue_status_t                       q_status,
    output logic                                          push,
    output scfp_pkg::frame_desc_t                         push_desc,
    output logic                                          wr_en,
    output logic [scfp_pkg::payload_idx_w(MAX_PAYLOAD):0] wr_addr,
    output logic [7:0]                                    wr_data
);
    import scfp_pkg::*;

    localparam int PW = payload_idx_w(MAX_PAYLOAD);

    localparam logic [2:0] PH_SOF1 = 3'd0;
    localparam logic [2:0] PH_SOF2 = 3'd1;
    localparam logic [2:0] PH_VER  = 3'd2;
    localparam logic [2:0] PH_CMD  = 3'd3;
    localparam logic [2:0] PH_SEQ  = 3'd4;
    localparam logic [2:0] PH_LEN  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_SUM  = 3'd7;

    logic [7:0]       sof_one_reg;
    logic [7:0]       sof_two_reg;
    logic [7:0]       version_reg;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       seq_reg, seq_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [PW-1:0]    fill_reg, fill_next;

    logic             beat;
    logic             hunt;
    logic [PW:0]      fill_plus;

    assign cfg_ready = 1'b1;
    // two good frames waiting means both buffer slots are taken
    assign s_ready   = !q_status.full;
    assign beat      = s_valid && s_ready;
    assign fill_plus = {1'b0, fill_reg} + (PW+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sof_one_reg <= SOF_ONE_RESET;
            sof_two_reg <= SOF_TWO_RESET;
            version_reg <= VERSION_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_ONE: sof_one_reg <= cfg_data;
                CFG_START_TWO: sof_two_reg <= cfg_data;
                CFG_VERSION:   version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        hunt       = 1'b0;
        if (beat) begin
            unique case (phase_reg)
                PH_SOF1: begin
                    if (s_rx_byte == sof_one_reg) phase_next = PH_SOF2;
                end
                PH_SOF2: begin
                    // a repeated first start byte keeps waiting for the second
                    if (s_rx_byte == sof_two_reg) phase_next = PH_VER;
                    else if (s_rx_byte != sof_one_reg) hunt = 1'b1;
                end
                PH_VER: begin
                    if (s_rx_byte == version_reg) begin
                        sum_next   = s_rx_byte;
                        phase_next = PH_CMD;
                    end else begin
                        hunt = 1'b1;
                    end
                end
                PH_CMD: begin
                    cmd_next   = s_rx_byte;
                    sum_next   = sum_reg + s_rx_byte;
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next   = s_rx_byte;
                    sum_next   = sum_reg + s_rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (s_rx_byte <= 8'(MAX_PAYLOAD)) begin
                        len_next   = s_rx_byte[LEN_W-1:0];
                        fill_next  = '0;
                        sum_next   = sum_reg + s_rx_byte;
                        phase_next = (s_rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                    end else begin
                        hunt = 1'b1;
                    end
                end
                PH_DATA: begin
                    fill_next = fill_plus[PW-1:0];
                    sum_next  = sum_reg + s_rx_byte;
                    if (7'(fill_plus) >= {1'b0, len_reg}) phase_next = PH_SUM;
                end
                PH_SUM: begin
                    hunt = 1'b1;
                end
                default: begin
                    hunt = 1'b1;
                end
            endcase
        end
        if (hunt) begin
            phase_next = PH_SOF1;
            cmd_next   = '0;
            seq_next   = '0;
            len_next   = '0;
            sum_next   = '0;
            fill_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SOF1;
            cmd_reg   <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            fill_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
        end
    end

    assign push = beat && (phase_reg == PH_SUM) && (sum_reg == s_rx_byte);
    assign push_desc.command      = cmd_reg;
    assign push_desc.sequence_res = seq_reg;
    assign push_desc.frame_length = len_reg;

    assign wr_en   = beat && (phase_reg == PH_DATA)
                     && ({1'b0, fill_reg} < (PW+1)'(MAX_PAYLOAD));
    assign wr_addr = {q_status.wr_slot, fill_reg};
    assign wr_data = s_rx_byte;

endmodule

`default_nettype wire

### sv/scfp_queue.sv
// two-entry queue of good-frame descriptors; each entry owns one payload slot
// uses scfp_pkg
`default_nettype none

module scfp_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  scfp_pkg::frame_desc_t   push_desc,
    input  wire                     pop,
    output scfp_pkg::frame_desc_t   head,
    output scfp_pkg::queue_status_t q_status
);
    import scfp_pkg::*;

    frame_desc_t desc_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) desc_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign head             = desc_reg[rd_ptr_reg];
    assign q_status.full    = (count_reg == 2'd2);
    assign q_status.empty   = (count_reg == 2'd0);
    assign q_status.wr_slot = wr_ptr_reg;
    assign q_status.rd_slot = rd_ptr_reg;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("descriptor pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("descriptor popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.empty || q_status.full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### sv/scfp_back.sv
// result emitter: holds the two-slot payload buffer and plays out a header
// beat and then the payload beats of the frame at the queue head; uses scfp_pkg
`default_nettype none

module scfp_back #(
    parameter int MAX_PAYLOAD = scfp_pkg::SCFP_MAX_PAYLOAD
) (
    input  wire                                           aclk,
    input  wire                                           aresetn,
    input  wire                                           wr_en,
    input  wire  [scfp_pkg::payload_idx_w(MAX_PAYLOAD):0] wr_addr,
    input  wire  [7:0]                                    wr_data,
    input  scfp_pkg::frame_desc_t                         head,
    input  scfp_pkg::queue_status_t                       q_status,
    output logic                                          pop,
    output logic                                          m_valid,
    input  wire                                           m_ready,
    output logic                                          m_item_kind,
    output logic [7:0]                                    m_command,
    output logic [7:0]                                    m_sequence_res,
    output logic [scfp_pkg::LEN_W-1:0]                    m_frame_length,
    output logic [7:0]                                    m_data_byte,
    output logic [scfp_pkg::POS_W-1:0]                    m_byte_position,
    output logic                                          m_final_item
);
    import scfp_pkg::*;

    localparam int PW        = payload_idx_w(MAX_PAYLOAD);
    localparam int MEM_DEPTH = 2 * (2 ** PW);

    logic [7:0]       mem [MEM_DEPTH];

    logic             active_reg;
    logic [PW-1:0]    next_pos_reg;

    logic             m_valid_reg;
    logic             kind_reg;
    logic [7:0]       cmd_reg;
    logic [7:0]       seq_reg;
    logic [LEN_W-1:0] len_reg;
    logic [7:0]       data_reg;
    logic [POS_W-1:0] pos_reg;
    logic             final_reg;

    logic             load;
    logic             start_hdr;
    logic             emit_data;
    logic             data_last;
    logic [PW:0]      rd_addr;

    // output register frees up when empty or taken this cycle
    assign load      = !m_valid_reg || m_ready;
    assign start_hdr = load && !active_reg && !q_status.empty;
    assign emit_data = load && active_reg;
    assign data_last = (7'(next_pos_reg) + 7'd1) == {1'b0, head.frame_length};
    assign pop       = (start_hdr && (head.frame_length == '0))
                       || (emit_data && data_last);
    assign rd_addr   = {q_status.rd_slot, next_pos_reg};

    // payload buffer; the read lands straight in the output data register
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (start_hdr) data_reg <= '0;
        else if (emit_data) data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (start_hdr || emit_data) begin
            kind_reg <= start_hdr ? KIND_HEADER : KIND_PAYLOAD;
            cmd_reg  <= head.command;
            seq_reg  <= head.sequence_res;
            len_reg  <= head.frame_length;
            pos_reg  <= start_hdr ? '0 : POS_W'(next_pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            final_reg    <= 1'b0;
            active_reg   <= 1'b0;
            next_pos_reg <= '0;
        end else begin
            if (load) m_valid_reg <= start_hdr || emit_data;
            if (start_hdr) begin
                final_reg    <= (head.frame_length == '0);
                active_reg   <= (head.frame_length != '0);
                next_pos_reg <= '0;
            end else if (emit_data) begin
                final_reg <= data_last;
                if (data_last) active_reg <= 1'b0;
                next_pos_reg <= next_pos_reg + PW'(1);
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_item_kind     = kind_reg;
    assign m_command       = cmd_reg;
    assign m_sequence_res  = seq_reg;
    assign m_frame_length  = len_reg;
    assign m_data_byte     = data_reg;
    assign m_byte_position = pos_reg;
    assign m_final_item    = final_reg;

    a_active_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> !q_status.empty)
        else $error("emitting payload with no frame at the queue head");

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (7'(next_pos_reg) < {1'b0, head.frame_length}))
        else $error("payload position past frame length");

    a_hdr_final_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (kind_reg == KIND_HEADER) && final_reg) |-> (len_reg == '0))
        else $error("header marked final on a frame with payload");

    a_pop_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid_reg && final_reg))
        else $error("frame released before its final beat was loaded");

endmodule

`default_nettype wire

### sv/sum_checked_frame_parser.sv
// top level of the sum-checked frame parser: parser front, descriptor queue,
// result emitter; depends on scfp_pkg, scfp_front, scfp_queue, scfp_back
//
//  channel | ports                     | direction | beat
//  --------+---------------------------+-----------+---------------------------------
//  config  | cfg_valid/ready/index/data| in        | one register write
//  input   | s_valid/ready, s_rx_byte  | in        | one received byte
//  result  | m_valid/ready, m_*        | out       | header or payload byte of a frame
//
// an input byte is taken every cycle while fewer than two good frames wait for
// the emitter; each buffered frame owns one of the two payload slots.
// a good frame plays out len+1 result beats, one per cycle with m_ready high; an idle
// emitter registers the header after the queue takes it; bad frames give nothing.
// aresetn is synchronous, active low; the payload buffer needs no clearing pass.
// a stall on the result side backs up into s_ready only once both slots fill.
`default_nettype none

module sum_checked_frame_parser #(
    parameter int MAX_PAYLOAD = scfp_pkg::SCFP_MAX_PAYLOAD
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [scfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [7:0]                       cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_item_kind,
    output logic [7:0]                       m_command,
    output logic [7:0]                       m_sequence_res,
    output logic [scfp_pkg::LEN_W-1:0]       m_frame_length,
    output logic [7:0]                       m_data_byte,
    output logic [scfp_pkg::POS_W-1:0]       m_byte_position,
    output logic                             m_final_item
);
    import scfp_pkg::*;

    localparam int PW = payload_idx_w(MAX_PAYLOAD);

    queue_status_t q_status;
    frame_desc_t   push_desc;
    frame_desc_t   head;
    logic          push;
    logic          pop;
    logic          wr_en;
    logic [PW:0]   wr_addr;
    logic [7:0]    wr_data;

    scfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    scfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    scfp_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .head            (head),
        .q_status        (q_status),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_command       (m_command),
        .m_sequence_res  (m_sequence_res),
        .m_frame_length  (m_frame_length),
        .m_data_byte     (m_data_byte),
        .m_byte_position (m_byte_position),
        .m_final_item    (m_final_item)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for sum_checked_frame_parser: random byte streams of good, bad and
// broken frames checked beat by beat against a predictor kept inside the bench
// depends on scfp_pkg and the sum_checked_frame_parser rtl
`timescale 1ns / 1ps

module tb;
    import scfp_pkg::*;

    localparam int SETTLE_CYCLES    = 20;
    localparam int SINK_HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        ST_HUNT, ST_SOF_TWO, ST_VERSION, ST_COMMAND,
        ST_SEQUENCE, ST_LENGTH, ST_PAYLOAD, ST_CHECKSUM
    } parse_state_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       cmd;
        logic [7:0]       seq_no;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             fin;
    } frame_beat_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_ONE;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_item_kind;
    logic [7:0]           m_command;
    logic [7:0]           m_sequence_res;
    logic [LEN_W-1:0]     m_frame_length;
    logic [7:0]           m_data_byte;
    logic [POS_W-1:0]     m_byte_position;
    logic                 m_final_item;

    // parser copy used for prediction
    logic [7:0]       cfg_sof_one = SOF_ONE_RESET;
    logic [7:0]       cfg_sof_two = SOF_TWO_RESET;
    logic [7:0]       cfg_version = VERSION_RESET;
    parse_state_t     parse_state = ST_HUNT;
    logic [7:0]       held_cmd    = 8'h00;
    logic [7:0]       held_seq    = 8'h00;
    logic [LEN_W-1:0] held_len    = '0;
    logic [7:0]       run_sum     = 8'h00;
    logic [LEN_W-1:0] fill_idx    = '0;
    logic [7:0]       payload_copy [SCFP_MAX_PAYLOAD];

    frame_beat_t frame_beats_due[$];
    logic [7:0]  frame_buf[$];

    int errors        = 0;
    int bytes_sent    = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_results  = 1'b0;

    sum_checked_frame_parser DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_command       (m_command),
        .m_sequence_res  (m_sequence_res),
        .m_frame_length  (m_frame_length),
        .m_data_byte     (m_data_byte),
        .m_byte_position (m_byte_position),
        .m_final_item    (m_final_item)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void restart_hunt();
        parse_state = ST_HUNT;
        held_cmd    = 8'h00;
        held_seq    = 8'h00;
        held_len    = '0;
        run_sum     = 8'h00;
        fill_idx    = '0;
    endfunction

    // advance the parser copy by one accepted byte, queue the beats of a good frame
    function automatic void advance_parser(input logic [7:0] b);
        frame_beat_t beat;
        case (parse_state)
            ST_HUNT: begin
                if (b == cfg_sof_one) parse_state = ST_SOF_TWO;
            end
            ST_SOF_TWO: begin
                if (b == cfg_sof_two) parse_state = ST_VERSION;
                else if (b != cfg_sof_one) restart_hunt();
            end
            ST_VERSION: begin
                if (b == cfg_version) begin
                    run_sum     = b;
                    parse_state = ST_COMMAND;
                end else begin
                    restart_hunt();
                end
            end
            ST_COMMAND: begin
                held_cmd    = b;
                run_sum     = run_sum + b;
                parse_state = ST_SEQUENCE;
            end
            ST_SEQUENCE: begin
                held_seq    = b;
                run_sum     = run_sum + b;
                parse_state = ST_LENGTH;
            end
            ST_LENGTH: begin
                if (b <= 8'(SCFP_MAX_PAYLOAD)) begin
                    held_len    = b[LEN_W-1:0];
                    fill_idx    = '0;
                    run_sum     = run_sum + b;
                    parse_state = (b == 8'h00) ? ST_CHECKSUM : ST_PAYLOAD;
                end else begin
                    restart_hunt();
                end
            end
            ST_PAYLOAD: begin
                if (fill_idx < LEN_W'(SCFP_MAX_PAYLOAD))
                    payload_copy[fill_idx[POS_W-1:0]] = b;
                fill_idx = fill_idx + LEN_W'(1);
                run_sum  = run_sum + b;
                if (fill_idx >= held_len) parse_state = ST_CHECKSUM;
            end
            ST_CHECKSUM: begin
                if (b == run_sum) begin
                    beat.kind   = KIND_HEADER;
                    beat.cmd    = held_cmd;
                    beat.seq_no = held_seq;
                    beat.len    = held_len;
                    beat.data   = 8'h00;
                    beat.pos    = '0;
                    beat.fin    = (held_len == '0);
                    frame_beats_due.push_back(beat);
                    for (int k = 0; k < int'(held_len); k++) begin
                        beat.kind = KIND_PAYLOAD;
                        beat.data = payload_copy[k[POS_W-1:0]];
                        beat.pos  = k[POS_W-1:0];
                        beat.fin  = (k + 1 == int'(held_len));
                        frame_beats_due.push_back(beat);
                    end
                end
                restart_hunt();
            end
            default: restart_hunt();
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        frame_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_beats_due.size() == 0) begin
                $display("%0t: result beat with none expected, actual cmd %0h data %0h",
                         $time, m_command, m_data_byte);
                errors++;
            end else begin
                want = frame_beats_due.pop_front();
                check_field("item_kind", 8'(want.kind), 8'(m_item_kind));
                check_field("command", want.cmd, m_command);
                check_field("sequence_res", want.seq_no, m_sequence_res);
                check_field("frame_length", 8'(want.len), 8'(m_frame_length));
                check_field("data_byte", want.data, m_data_byte);
                check_field("byte_position", 8'(want.pos), 8'(m_byte_position));
                check_field("final_item", 8'(want.fin), 8'(m_final_item));
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                hold_results = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        advance_parser(b);
    endtask

    task automatic flush_buf();
        while (frame_buf.size() != 0) send_byte(frame_buf.pop_front());
    endtask

    // waits with the input idle until every queued beat has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (frame_beats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_START_ONE: cfg_sof_one = val;
            CFG_START_TWO: cfg_sof_two = val;
            CFG_VERSION:   cfg_version = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] sof_one, input logic [7:0] sof_two,
                                  input logic [7:0] version);
        drain();
        write_reg(CFG_START_ONE, sof_one);
        write_reg(CFG_START_TWO, sof_two);
        write_reg(CFG_VERSION, version);
        cfg_valid <= 1'b0;
    endtask

    // one frame under the current settings; cut >= 0 keeps only the first cut bytes
    task automatic send_frame(input int len, input bit good, input int extra_sof,
                              input int cut);
        logic [7:0] chk;
        logic [7:0] b;
        frame_buf = {};
        repeat (extra_sof + 1) frame_buf.push_back(cfg_sof_one);
        frame_buf.push_back(cfg_sof_two);
        frame_buf.push_back(cfg_version);
        chk = cfg_version;
        // cmd, seq, len, then payload
        for (int i = 0; i < len + 3; i++) begin
            b = (i == 2) ? 8'(len) : 8'($urandom);
            frame_buf.push_back(b);
            chk = chk + b;
        end
        if (!good) chk = chk ^ 8'($urandom_range(1, 255));
        frame_buf.push_back(chk);
        if (cut >= 0)
            while (frame_buf.size() > cut) frame_buf.delete(frame_buf.size() - 1);
        flush_buf();
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 8);
        if (r < 95) return $urandom_range(9, SCFP_MAX_PAYLOAD - 1);
        return SCFP_MAX_PAYLOAD;
    endfunction

    task automatic send_random_chunk();
        int r;
        int len;
        r   = $urandom_range(0, 99);
        len = pick_len();
        if (r < 70) begin
            send_frame(len, $urandom_range(0, 99) < 85, 0, -1);
        end else if (r < 78) begin
            send_frame(len, 1'b1, $urandom_range(1, 3), -1);
        end else if (r < 84) begin
            send_frame($urandom_range(SCFP_MAX_PAYLOAD + 1, 255), 1'b1, 0, 6);
        end else if (r < 89) begin
            frame_buf = {cfg_sof_one, cfg_sof_two, cfg_version ^ 8'($urandom_range(1, 255))};
            flush_buf();
        end else if (r < 94) begin
            // frame cut short, whatever follows lands in its payload
            send_frame(len, 1'b1, 0, $urandom_range(4, len + 6));
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    task automatic run_chunks(input int n, input bit quiet);
        int stop;
        stop = bytes_sent + n;
        while (bytes_sent < stop) begin
            if (quiet) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                if ($urandom_range(0, 3) == 0) src_idle_pct = $urandom_range(0, 1) ? 25 : 0;
                if ($urandom_range(0, 3) == 0) sink_idle_pct = $urandom_range(0, 1) ? 25 : 0;
            end
            send_random_chunk();
        end
    endtask

    task automatic test_directed_frames();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // repeated first start byte, zero length, checksum wraps to zero
        frame_buf = {SOF_ONE_RESET, SOF_ONE_RESET, SOF_TWO_RESET, VERSION_RESET,
                     8'hFF, 8'h00, 8'h00, 8'h00};
        flush_buf();
        // wrong version
        frame_buf = {SOF_ONE_RESET, SOF_TWO_RESET, 8'h02};
        flush_buf();
        // length one past the maximum
        frame_buf = {SOF_ONE_RESET, SOF_TWO_RESET, VERSION_RESET, 8'h00, 8'hFF, 8'h21};
        flush_buf();
        // two payload bytes at the byte extremes
        frame_buf = {SOF_ONE_RESET, SOF_TWO_RESET, VERSION_RESET, 8'h80, 8'h7F, 8'h02,
                     8'hFF, 8'h00, 8'h01};
        flush_buf();
        // bad checksum, dropped
        frame_buf = {SOF_ONE_RESET, SOF_TWO_RESET, VERSION_RESET, 8'h01, 8'h01, 8'h00,
                     8'h00};
        flush_buf();
        // wrong second start byte, not taken as a new first start byte
        frame_buf = {SOF_ONE_RESET, 8'h12, SOF_TWO_RESET};
        flush_buf();
        drain();
    endtask

    task automatic test_config_sweep();
        apply_settings(8'h00, 8'hFF, 8'h00);
        run_chunks(20, 1'b0);
        apply_settings(8'hFF, 8'h00, 8'hFF);
        run_chunks(20, 1'b0);
        // same value for both start bytes
        apply_settings(8'h3C, 8'h3C, 8'h7E);
        run_chunks(20, 1'b0);
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
        run_chunks(20, 1'b0);
        apply_settings(SOF_ONE_RESET, SOF_TWO_RESET, VERSION_RESET);
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_results  = 1'b1;
        // enough full frames to fill both slots and stall the input
        repeat (3) send_frame(SCFP_MAX_PAYLOAD, 1'b1, 0, -1);
        drain();
    endtask

    task automatic test_random_stream();
        run_chunks(70, 1'b0);
        drain();
        run_chunks(60, 1'b0);
        run_chunks(40, 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_config_sweep();
        test_backpressure();
        test_random_stream();
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
